// ===== rtl/bmhq_pkg.sv =====
// Package for the binary min-heap priority queue.
// Holds sizes, status codes, beat types and the controller/datapath interface.
// No dependencies.
`default_nettype none

package bmhq_pkg;

  // Sizes of the heap and its entries.
  localparam int HEAP_DEPTH    = 64;
  localparam int KEY_WIDTH     = 32;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int ADDR_W        = $clog2(HEAP_DEPTH);
  localparam int CNT_W         = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W         = ADDR_W + 2;
  localparam int ENTRY_W       = KEY_WIDTH + PAYLOAD_WIDTH;

  // Request and status codes.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Request beat.
  typedef struct packed {
    logic        req_type;
    logic [31:0] key_in;
    logic [15:0] payload_in;
  } bmhq_req_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [15:0] payload_out;
    logic        is_empty;
    logic [6:0]  entry_count;
  } bmhq_rsp_t;

  // Read address selection for the heap store.
  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } bmhq_rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         ld_req;
    logic         cnt_inc;
    logic         cnt_dec;
    bmhq_rd_sel_t rd_sel;
    logic         ld_root;
    logic         ld_last;
    logic         ld_best;
    logic         up_step;
    logic         dn_step;
    logic         place;
  } bmhq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_ext;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic has_left;
    logic dn_stop;
  } bmhq_stat_t;

  // True when key a orders strictly before key b.
  function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 sgn);
    logic [KEY_WIDTH-1:0] top;
    top = {sgn, {(KEY_WIDTH-1){1'b0}}};
    return (a ^ top) < (b ^ top);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue, top level: controller plus datapath.
// An insert sifts up from the new last slot and an extract sifts down from the root;
// a refused request finishes straight from idle without writing the store.
// One request at a time; each sift level costs a store read, a compare and a write.
// The result beat shows for one cycle with done; the receiver cannot stall it.
// Reset clears the entry count and the key mode; store contents are not cleared.
`default_nettype none

module binary_min_heap_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output      logic                busy,
  input  wire bmhq_pkg::bmhq_req_t req,
  output      logic                done,
  output      bmhq_pkg::bmhq_rsp_t rsp,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);
  import bmhq_pkg::*;

  bmhq_cmd_t  cmd;
  bmhq_stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bmhq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // A result beat is only issued on the return to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // A refused insert reports a full heap.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> rsp.entry_count == 7'(HEAP_DEPTH))
    else $error("full status with heap not full");

  // A refused extract reports an empty heap and a zero entry.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |-> (rsp.is_empty && rsp.key_out == '0))
    else $error("empty status with data or entries");
`endif

endmodule

`default_nettype wire

// ===== rtl/bmhq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bmhq_datapath.sv =====
// Datapath of the heap queue: entry count, moving entry, compares and the store.
// Depends on bmhq_pkg and bmhq_ram.
`default_nettype none

module bmhq_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire bmhq_pkg::bmhq_req_t req,
  input  wire bmhq_pkg::bmhq_cmd_t cmd,
  output      bmhq_pkg::bmhq_stat_t stat,
  output      bmhq_pkg::bmhq_rsp_t rsp
);
  import bmhq_pkg::*;

  logic                     key_signed;
  logic [CNT_W-1:0]         count;
  logic [ENTRY_W-1:0]       cur;
  logic [ADDR_W-1:0]        pos;
  logic [ENTRY_W-1:0]       best_ent;
  logic                     best_left;
  logic [1:0]               out_status;
  logic [KEY_WIDTH-1:0]     out_key;
  logic [PAYLOAD_WIDTH-1:0] out_pay;

  logic [ENTRY_W-1:0]       rd_data;
  logic [ADDR_W-1:0]        raddr;
  logic [ENTRY_W-1:0]       wdata;
  logic                     we;
  logic [IDX_W-1:0]         left_idx;
  logic [IDX_W-1:0]         right_idx;
  logic [ADDR_W-1:0]        parent;
  logic                     has_left;
  logic                     has_right;
  logic                     right_wins;
  logic                     rd_less_cur;
  logic                     cur_less_rd;
  logic                     full;
  logic                     empty;

  // Index arithmetic around the current position.
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + IDX_W'(1);
  assign parent    = (pos - ADDR_W'(1)) >> 1;
  assign has_left  = left_idx < IDX_W'(count);
  assign has_right = right_idx < IDX_W'(count);
  assign full      = count == CNT_W'(HEAP_DEPTH);
  assign empty     = count == '0;

  // Key compares against the entry just read.
  assign rd_less_cur = key_less(rd_data[ENTRY_W-1 -: KEY_WIDTH],
                                cur[ENTRY_W-1 -: KEY_WIDTH], key_signed);
  assign cur_less_rd = key_less(cur[ENTRY_W-1 -: KEY_WIDTH],
                                rd_data[ENTRY_W-1 -: KEY_WIDTH], key_signed);
  assign right_wins  = has_right &&
                       key_less(rd_data[ENTRY_W-1 -: KEY_WIDTH],
                                best_ent[ENTRY_W-1 -: KEY_WIDTH], key_signed);

  // Status toward the controller.
  assign stat.req_ext  = req.req_type == REQ_EXTRACT;
  assign stat.full     = full;
  assign stat.empty    = empty;
  assign stat.pos_zero = pos == '0;
  assign stat.up_less  = cur_less_rd;
  assign stat.has_left = has_left;
  assign stat.dn_stop  = !right_wins && !best_left;

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_ROOT:   raddr = '0;
      RD_LAST:   raddr = count[ADDR_W-1:0];
      RD_PARENT: raddr = parent;
      RD_LEFT:   raddr = left_idx[ADDR_W-1:0];
      RD_RIGHT:  raddr = right_idx[ADDR_W-1:0];
      default:   raddr = '0;
    endcase
  end

  // Write back: the moving entry at its final place, or a displaced entry.
  assign we = cmd.place || cmd.up_step || cmd.dn_step;
  always_comb begin
    priority if (cmd.place) begin
      wdata = cur;
    end else if (cmd.up_step || right_wins) begin
      wdata = rd_data;
    end else begin
      wdata = best_ent;
    end
  end

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Control registers: entry count and the key mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      key_signed <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_signed <= cfg_wdata;
      end
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Working registers and the result registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      cur     <= {req.key_in[KEY_WIDTH-1:0], req.payload_in[PAYLOAD_WIDTH-1:0]};
      pos     <= count[ADDR_W-1:0];
      out_key <= '0;
      out_pay <= '0;
      if (req.req_type == REQ_INSERT && full) begin
        out_status <= ST_FULL;
      end else if (req.req_type == REQ_EXTRACT && empty) begin
        out_status <= ST_EMPTY;
      end else begin
        out_status <= ST_OK;
      end
    end
    if (cmd.ld_root) begin
      out_key <= rd_data[ENTRY_W-1 -: KEY_WIDTH];
      out_pay <= rd_data[PAYLOAD_WIDTH-1:0];
    end
    if (cmd.ld_last) begin
      cur <= rd_data;
      pos <= '0;
    end
    if (cmd.ld_best) begin
      best_left <= rd_less_cur;
      best_ent  <= rd_less_cur ? rd_data : cur;
    end
    if (cmd.up_step) begin
      pos <= parent;
    end
    if (cmd.dn_step) begin
      pos <= right_wins ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    end
  end

  // Result fields.
  assign rsp.status      = out_status;
  assign rsp.key_out     = 32'(out_key);
  assign rsp.payload_out = 16'(out_pay);
  assign rsp.is_empty    = empty;
  assign rsp.entry_count = 7'(count);

endmodule

`default_nettype wire

// ===== rtl/bmhq_ctrl.sv =====
// Controller of the heap queue: sequences reads, compares and writes of a sift.
// Depends on bmhq_pkg.
`default_nettype none

module bmhq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire bmhq_pkg::bmhq_stat_t stat,
  output      bmhq_pkg::bmhq_cmd_t  cmd,
  output      logic                 busy,
  output      logic                 done
);
  import bmhq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_DN_RDL,
    S_DN_L,
    S_DN_R
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;

  assign busy = state != S_IDLE;

  // Commands and next state for each step of a sift.
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_ROOT;
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          if (!stat.req_ext) begin
            if (stat.full) begin
              finish = 1'b1;
            end else begin
              cmd.cnt_inc = 1'b1;
              state_next  = S_INS_RD;
            end
          end else begin
            if (stat.empty) begin
              finish = 1'b1;
            end else begin
              cmd.cnt_dec = 1'b1;
              state_next  = S_EXT_ROOT;
            end
          end
        end
      end
      S_INS_RD: begin
        if (stat.pos_zero) begin
          cmd.place  = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.up_less) begin
          cmd.up_step = 1'b1;
          state_next  = S_INS_RD;
        end else begin
          cmd.place  = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXT_ROOT: begin
        cmd.ld_root = 1'b1;
        if (stat.empty) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sel = RD_LAST;
          state_next = S_EXT_LAST;
        end
      end
      S_EXT_LAST: begin
        cmd.ld_last = 1'b1;
        state_next  = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (!stat.has_left) begin
          cmd.place  = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_L;
        end
      end
      S_DN_L: begin
        cmd.ld_best = 1'b1;
        cmd.rd_sel  = RD_RIGHT;
        state_next  = S_DN_R;
      end
      S_DN_R: begin
        if (stat.dn_stop) begin
          cmd.place  = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_RDL;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

endmodule

`default_nettype wire
